// File: rtl/core/tia_pkg.sv
package tia_pkg;

	localparam int LOGIT_BITS = 16;
	localparam int LABEL_BITS = 8;
	localparam int FRAC_BITS = 8;
	localparam int MAX_CLASSES = 256;
	localparam int QUEUE_DEPTH = 4;

	// class index stops here: min(MAX_CLASSES - 1, 255)
	localparam logic [LABEL_BITS-1:0] COUNT_LIMIT =
		(MAX_CLASSES - 1 > 255) ? LABEL_BITS'(255) : LABEL_BITS'(MAX_CLASSES - 1);

	typedef logic signed [LOGIT_BITS-1:0] logit_t;

	localparam logit_t LOGIT_MIN = {1'b1, {(LOGIT_BITS-1){1'b0}}};

	typedef struct packed {
		logit_t                corner_000;
		logit_t                corner_001;
		logit_t                corner_010;
		logit_t                corner_011;
		logit_t                corner_100;
		logit_t                corner_101;
		logit_t                corner_110;
		logit_t                corner_111;
		logic [FRAC_BITS-1:0]  frac_depth;
		logic [FRAC_BITS-1:0]  frac_row;
		logic [FRAC_BITS-1:0]  frac_col;
		logic                  final_class;
	} item_t;

	typedef struct packed {
		logic [LABEL_BITS-1:0] label;
		logit_t                label_score;
	} result_t;

	// one interpolated class value on its way to the argmax
	typedef struct packed {
		logit_t val;
		logic   last;
	} tia_q_t;

endpackage

// File: rtl/core/tia_front.sv
module tia_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tia_pkg::item_t item,
	output logic           q_push,
	input  logic           q_full,
	output tia_pkg::tia_q_t q_data
);
	import tia_pkg::*;

	// a + floor((b - a) * t / 256), same as floor((a*(256-t) + b*t) / 256)
	function automatic logit_t lerp(logit_t a, logit_t b, logic [FRAC_BITS-1:0] t);
		logic signed [LOGIT_BITS:0]   d;
		logic signed [LOGIT_BITS+9:0] p;
		logic signed [LOGIT_BITS+1:0] s;
		d = $signed({b[LOGIT_BITS-1], b}) - $signed({a[LOGIT_BITS-1], a});
		p = d * $signed({1'b0, t});
		s = $signed({{2{a[LOGIT_BITS-1]}}, a}) + $signed(p[LOGIT_BITS+9:8]);
		return s[LOGIT_BITS-1:0];
	endfunction

	logic adv;

	logit_t               c00_s1, c10_s1, c01_s1, c11_s1;
	logic [FRAC_BITS-1:0] th_s1, td_s1;
	logic                 last_s1, v_s1;

	logit_t               c0_s2, c1_s2;
	logic [FRAC_BITS-1:0] td_s2;
	logic                 last_s2, v_s2;

	logit_t               val_s3;
	logic                 last_s3, v_s3;

	// whole pipe holds while the last stage cannot drain
	assign adv    = !(v_s3 && q_full);
	assign full   = !adv;
	assign q_push = v_s3 && !q_full;
	assign q_data = '{val: val_s3, last: last_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			c00_s1  <= lerp(item.corner_000, item.corner_001, item.frac_col);
			c10_s1  <= lerp(item.corner_010, item.corner_011, item.frac_col);
			c01_s1  <= lerp(item.corner_100, item.corner_101, item.frac_col);
			c11_s1  <= lerp(item.corner_110, item.corner_111, item.frac_col);
			th_s1   <= item.frac_row;
			td_s1   <= item.frac_depth;
			last_s1 <= item.final_class;

			c0_s2   <= lerp(c00_s1, c10_s1, th_s1);
			c1_s2   <= lerp(c01_s1, c11_s1, th_s1);
			td_s2   <= td_s1;
			last_s2 <= last_s1;

			val_s3  <= lerp(c0_s2, c1_s2, td_s2);
			last_s3 <= last_s2;
		end
	end

endmodule

// File: rtl/core/tia_queue.sv
module tia_queue #(
	parameter int DEPTH = tia_pkg::QUEUE_DEPTH
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tia_pkg::tia_q_t wr_data,
	output logic            full,
	input  logic            pop,
	output tia_pkg::tia_q_t rd_data,
	output logic            empty
);
	import tia_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	tia_q_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue write while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue read while empty");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/tia_back.sv
module tia_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  tia_pkg::tia_q_t  q_data,
	output logic             q_pop,
	input  logic             pop,
	output logic             empty,
	output tia_pkg::result_t result
);
	import tia_pkg::*;

	logit_t                max_q;
	logic [LABEL_BITS-1:0] label_q;
	logic [LABEL_BITS-1:0] count_q;
	logic                  out_valid_q;
	result_t               result_q;

	logic                  take;
	logit_t                sel_max;
	logic [LABEL_BITS-1:0] sel_label;

	// first class always wins, later ones only when strictly greater
	assign take      = (count_q == '0) || (q_data.val > max_q);
	assign sel_max   = take ? q_data.val : max_q;
	assign sel_label = take ? count_q : label_q;

	// a last beat needs the output register free (or draining)
	assign q_pop  = !q_empty && (!q_data.last || !out_valid_q || pop);
	assign empty  = !out_valid_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q       <= LOGIT_MIN;
			label_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				if (q_data.last) begin
					max_q   <= LOGIT_MIN;
					label_q <= '0;
					count_q <= '0;
				end else begin
					max_q   <= sel_max;
					label_q <= sel_label;
					if (count_q < COUNT_LIMIT)
						count_q <= count_q + 1'b1;
				end
			end
			if (q_pop && q_data.last)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && q_data.last)
			result_q <= '{label: sel_label, label_score: sel_max};
	end

`ifndef SYNTHESIS
	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && q_data.last |=> !empty && count_q == '0)
		else $error("last class did not produce a result or clear state");
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && !q_data.last && count_q < COUNT_LIMIT |=> count_q == $past(count_q) + 1'b1)
		else $error("class counter did not advance");
	a_label_bound: assert property (@(posedge clk) disable iff (!arst_n)
		label_q <= count_q)
		else $error("running label ahead of class counter");
`endif

endmodule

// File: rtl/core/trilinear_interp_argmax_unit.sv
// path: a final-class beat passes stages s1, s2, s3, the queue and the result register
// throughput: one beat per cycle, set by the three-stage interpolation pipe (one lerp level each)
// and the combinational compare in the argmax stage; a full queue stalls the pipe
// a last class waits in the queue while an earlier result is still untaken
// reset: arst_n clears the pipe, queue pointers, result flag and argmax state at once
module trilinear_interp_argmax_unit #(
	parameter int QUEUE_DEPTH = tia_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tia_pkg::item_t   item,
	output logic             empty,
	input  logic             pop,
	output tia_pkg::result_t result
);
	import tia_pkg::*;

	logic   q_push, q_full, q_pop, q_empty;
	tia_q_t q_wr, q_rd;

	tia_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_push (q_push),
		.q_full (q_full),
		.q_data (q_wr)
	);

	tia_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.full    (q_full),
		.pop     (q_pop),
		.rd_data (q_rd),
		.empty   (q_empty)
	);

	tia_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (q_rd),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule
